// ----- hdl/half_float_adder_macros.svh -----
// Assertion macros for the half-precision adder
`ifndef HALF_FLOAT_ADDER_MACROS_SVH
`define HALF_FLOAT_ADDER_MACROS_SVH
`ifndef NO_ASSERTIONS
// implication checked every cycle outside reset
`define HFA_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
// implication checked in the following cycle
`define HFA_ASSERT_NXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define HFA_ASSERT_IMP(label, clk, rst, cond, prop, msg)
`define HFA_ASSERT_NXT(label, clk, rst, cond, prop, msg)
`endif
`endif

// ----- hdl/hfa_pkg.sv -----
// Shared types and constants for the half-precision adder
`timescale 1ns / 1ps
package hfa_pkg;
  localparam logic [15:0] POS_INF = 16'h7C00;
  localparam logic [15:0] NEG_INF = 16'hFC00;
  localparam logic [15:0] NAN_VAL = 16'h7C01;
  localparam logic [4:0] EXP_MAX = 5'b11111;
  localparam int QDEPTH = 2;

  // classified beat passed from front to back
  typedef struct packed {
    logic        special;   // result already known
    logic [15:0] special_val;
    logic        sa;
    logic        sb;
    logic [4:0]  ea;
    logic [4:0]  eb;
    logic [10:0] ma;
    logic [10:0] mb;
  } cls_t;
endpackage

// ----- hdl/half_float_adder.sv -----
// Top level of the half-precision adder
`timescale 1ns / 1ps
`include "half_float_adder_macros.svh"
// Takes an operand pair whenever start is high and busy is low; the sum
// appears on sum_value with done high for one cycle, through the queue
// storage and the result register. A beat can be taken every cycle: the back
// end drains one queue entry per cycle, so busy stays low in steady use. The sink cannot stall.
module half_float_adder (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] operand_a,
  input  logic [15:0] operand_b,
  output logic        busy,
  output logic        done,
  output logic [15:0] sum_value
);
  logic          q_full, q_push, q_pop, q_valid;
  hfa_pkg::cls_t q_in, q_head;

  hfa_front u_front (.start(start), .operand_a(operand_a),
    .operand_b(operand_b), .q_full(q_full), .busy(busy), .q_push(q_push), .q_data(q_in));
  hfa_queue u_queue (.clk(clk), .rst(rst), .push(q_push), .push_data(q_in), .pop(q_pop),
    .full(q_full), .not_empty(q_valid), .head(q_head));
  hfa_back u_back (.clk(clk), .rst(rst), .q_valid(q_valid), .q_head(q_head),
    .q_pop(q_pop), .done(done), .sum_value(sum_value));

  `HFA_ASSERT_NXT(a_push_done, clk, rst, q_push, ##1 done, "accepted beat gave no result")
  `HFA_ASSERT_IMP(a_no_pop_empty, clk, rst, q_pop, q_valid, "pop from empty queue")
  `HFA_ASSERT_IMP(a_busy_full, clk, rst, busy, q_full, "busy without full queue")
endmodule

// ----- hdl/hfa_front.sv -----
// Front end: decodes operands and resolves infinities and NaNs
`timescale 1ns / 1ps
module hfa_front (
  input  logic              start,
  input  logic [15:0]       operand_a,
  input  logic [15:0]       operand_b,
  input  logic              q_full,
  output logic              busy,
  output logic              q_push,
  output hfa_pkg::cls_t     q_data
);
  logic        ea_max, eb_max, a_inf, b_inf, a_nan, b_nan;
  hfa_pkg::cls_t cls_next;

  assign busy = q_full;
  assign q_push = start && !q_full;

  always_comb begin
    ea_max = operand_a[14:10] == hfa_pkg::EXP_MAX;
    eb_max = operand_b[14:10] == hfa_pkg::EXP_MAX;
    a_inf = ea_max && operand_a[9:0] == 10'd0;
    b_inf = eb_max && operand_b[9:0] == 10'd0;
    a_nan = ea_max && operand_a[9:0] != 10'd0;
    b_nan = eb_max && operand_b[9:0] != 10'd0;
    cls_next.sa = operand_a[15];
    cls_next.sb = operand_b[15];
    cls_next.ea = operand_a[14:10];
    cls_next.eb = operand_b[14:10];
    // zero exponent flushes the operand
    cls_next.ma = (operand_a[14:10] == 5'd0) ? 11'd0 : {1'b1, operand_a[9:0]};
    cls_next.mb = (operand_b[14:10] == 5'd0) ? 11'd0 : {1'b1, operand_b[9:0]};
    cls_next.special = 1'b1;
    cls_next.special_val = hfa_pkg::NAN_VAL;
    if (a_inf) begin
      if (!(b_inf && operand_a[15] != operand_b[15]))
        cls_next.special_val = operand_a[15] ? hfa_pkg::NEG_INF : hfa_pkg::POS_INF;
    end else if (a_nan || b_nan) begin
      cls_next.special_val = hfa_pkg::NAN_VAL;
    end else if (b_inf) begin
      cls_next.special_val = operand_b;
    end else begin
      cls_next.special = 1'b0;
    end
  end

  assign q_data = cls_next;
endmodule

// ----- hdl/hfa_queue.sv -----
// Short queue between front and back ends
`timescale 1ns / 1ps
module hfa_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hfa_pkg::cls_t push_data,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output hfa_pkg::cls_t head
);
  hfa_pkg::cls_t mem [hfa_pkg::QDEPTH];
  logic [0:0] wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full = count == 2'(hfa_pkg::QDEPTH);
  assign not_empty = count != 2'd0;
  assign head = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

// ----- hdl/hfa_back.sv -----
// Back end: align, add/subtract, normalize and pack
`timescale 1ns / 1ps
module hfa_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  hfa_pkg::cls_t q_head,
  output logic          q_pop,
  output logic          done,
  output logic [15:0]   sum_value
);
  logic [4:0]  d, er0;
  logic [10:0] ma, mb;
  logic        sr, neg, zero;
  logic [11:0] mr;
  logic [10:0] mn;
  logic [6:0]  er;
  logic [3:0]  lz;
  logic [15:0] res_next;

  assign q_pop = q_valid;

  // leading zero count over the 11-bit difference
  function automatic logic [3:0] lzc(input logic [10:0] v);
    logic [3:0] n;
    n = 4'd11;
    for (int i = 0; i <= 10; i++) begin
      if (v[i]) n = 4'(10 - i);
    end
    return n;
  endfunction

  always_comb begin
    ma = q_head.ma;
    mb = q_head.mb;
    er0 = q_head.ea;
    // alignment of the smaller exponent
    if (q_head.ea > q_head.eb) begin
      d = q_head.ea - q_head.eb;
      mb = (d > 5'd15) ? 11'd0 : (mb >> d);
    end else begin
      d = q_head.eb - q_head.ea;
      ma = (d > 5'd15) ? 11'd0 : (ma >> d);
      er0 = q_head.eb;
    end
    neg = q_head.sa != q_head.sb;
    zero = 1'b0;
    sr = q_head.sa;
    mr = 12'd0;
    mn = 11'd0;
    lz = 4'd0;
    er = {2'b00, er0};
    if (neg) begin
      if (ma > mb) mr = {1'b0, ma - mb};
      else if (mb > ma) begin
        mr = {1'b0, mb - ma};
        sr = q_head.sb;
      end else zero = 1'b1;
      lz = lzc(mr[10:0]);
      mn = mr[10:0] << lz;
      er = er - 7'(lz);
    end else begin
      mr = {1'b0, ma} + {1'b0, mb};
      if (mr[11]) begin
        mn = mr[11:1];
        er = er + 7'd1;
      end else mn = mr[10:0];
    end
    // packing with flush and saturation
    if (q_head.special) res_next = q_head.special_val;
    else if (zero) res_next = 16'h0000;
    else if (mn == 11'd0 || er[6] || er == 7'd0) res_next = {sr, 15'd0};
    else if (er >= 7'd31) res_next = {sr, 15'h7C00};
    else res_next = {sr, er[4:0], mn[9:0]};
  end

  // result register, one strobe per beat
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= q_valid;
    if (q_valid) sum_value <= res_next;
  end
endmodule

// ----- dv/tb_half_float_adder.sv -----
// Testbench for the half-precision adder: directed and random operand pairs
`timescale 1ns / 1ps
module tb_half_float_adder;
  logic        clk;
  logic        rst;
  logic        start;
  logic [15:0] operand_a;
  logic [15:0] operand_b;
  logic        busy;
  logic        done;
  logic [15:0] sum_value;

  logic [15:0] sum_queue[$];
  int          fail_count;

  half_float_adder uut (
    .clk(clk), .rst(rst), .start(start), .operand_a(operand_a),
    .operand_b(operand_b), .busy(busy), .done(done), .sum_value(sum_value)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // expected sum: align, add or subtract, normalize, truncate
  function automatic logic [15:0] half_sum(input logic [15:0] a, input logic [15:0] b);
    logic        sa, sb, sr;
    logic [4:0]  ea, eb;
    logic [9:0]  fa, fb;
    logic [11:0] ma, mb, mr;
    int          er, d, i;
    logic        a_inf, b_inf, a_nan, b_nan;
    sa = a[15];
    sb = b[15];
    ea = a[14:10];
    eb = b[14:10];
    fa = a[9:0];
    fb = b[9:0];
    a_inf = (ea == hfa_pkg::EXP_MAX) && (fa == 0);
    b_inf = (eb == hfa_pkg::EXP_MAX) && (fb == 0);
    a_nan = (ea == hfa_pkg::EXP_MAX) && (fa != 0);
    b_nan = (eb == hfa_pkg::EXP_MAX) && (fb != 0);
    if (a_inf) begin
      if (b_inf && sa != sb) return hfa_pkg::NAN_VAL;
      return sa ? hfa_pkg::NEG_INF : hfa_pkg::POS_INF;
    end
    if (a_nan || b_nan) return hfa_pkg::NAN_VAL;
    if (b_inf) return b;
    ma = (ea == 0) ? 12'd0 : {2'b01, fa};
    mb = (eb == 0) ? 12'd0 : {2'b01, fb};
    if (ea > eb) begin
      d = ea - eb;
      mb = (d > 15) ? 12'd0 : (mb >> d);
      er = ea;
    end else begin
      d = eb - ea;
      ma = (d > 15) ? 12'd0 : (ma >> d);
      er = eb;
    end
    if (sa != sb) begin
      if (ma > mb) begin
        sr = sa;
        mr = ma - mb;
      end else if (mb > ma) begin
        sr = sb;
        mr = mb - ma;
      end else begin
        return 16'h0000;
      end
      for (i = 0; i < 11 && mr[10] == 1'b0; i++) begin
        mr = mr << 1;
        er--;
      end
    end else begin
      sr = sa;
      mr = ma + mb;
      if (mr[11]) begin
        mr = mr >> 1;
        er++;
      end
    end
    if (mr == 0 || er < 1) return {sr, 15'd0};
    if (er >= 31) return {sr, hfa_pkg::EXP_MAX, 10'd0};
    return {sr, er[4:0], mr[9:0]};
  endfunction

  // send one beat, with an optional random gap first
  task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input bit gaps);
    int gap;
    if (gaps) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
            ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start <= 1'b1;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    sum_queue.push_back(half_sum(a, b));
  endtask

  // stop sending, then wait until every expected sum has come back
  task automatic drain;
    start <= 1'b0;
    while (sum_queue.size() != 0) @(posedge clk);
  endtask

  // random half value biased toward interesting exponents
  function automatic logic [15:0] rand_half();
    logic [4:0] e;
    case ($urandom_range(0, 7))
      0: e = 5'd0;
      1: e = hfa_pkg::EXP_MAX;
      2: e = 5'd30;
      3: e = 5'd1;
      default: e = 5'($urandom_range(0, 31));
    endcase
    return {1'($urandom), e, 10'($urandom)};
  endfunction

  // check each result beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (sum_queue.size() == 0) begin
        $display("%0t: unexpected sum_value %h", $time, sum_value);
        fail_count++;
      end else begin
        if (sum_value !== sum_queue[0]) begin
          $display("%0t: sum_value expected %h actual %h", $time, sum_queue[0], sum_value);
          fail_count++;
        end
        void'(sum_queue.pop_front());
      end
    end
  end

  // extremes, infinities, NaNs, zeros, cancellation, overflow, underflow
  task automatic test_special_cases;
    send_pair(16'h0000, 16'h0000, 0);
    send_pair(16'h8000, 16'h8000, 0);
    send_pair(16'h8000, 16'h0000, 0);
    send_pair(16'h3C00, 16'hBC00, 0);
    send_pair(16'h7C00, 16'hFC00, 0);
    send_pair(16'hFC00, 16'h7C00, 0);
    send_pair(16'h7C00, 16'h7C00, 0);
    send_pair(16'h7C00, 16'h7E00, 0);
    send_pair(16'hFC00, 16'hFC01, 0);
    send_pair(16'h7C01, 16'h3C00, 0);
    send_pair(16'h3C00, 16'hFFFF, 0);
    send_pair(16'h3C00, 16'h7C00, 0);
    send_pair(16'h3C00, 16'hFC00, 0);
    send_pair(16'h7BFF, 16'h7BFF, 0);
    send_pair(16'hFBFF, 16'hFBFF, 0);
    send_pair(16'h0400, 16'h83FF, 0);
    send_pair(16'h0401, 16'h8400, 0);
    send_pair(16'h03FF, 16'h0001, 0);
    send_pair(16'h3C00, 16'h0001, 0);
    send_pair(16'h7800, 16'h0400, 0);
    send_pair(16'h3FFF, 16'hBFFE, 0);
    send_pair(16'hFFFF, 16'hFFFF, 0);
    drain();
  endtask

  // random pairs, with gaps after the first 300, one pause until all sums are back
  task automatic test_random_pairs;
    int k;
    logic [15:0] a;
    for (k = 0; k < 750; k++) begin
      a = rand_half();
      if ($urandom_range(0, 3) == 0)
        send_pair(a, {~a[15], a[14:10], 10'($urandom)}, k >= 300);
      else
        send_pair(a, rand_half(), k >= 300);
      if (k == 400) drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    operand_a = 16'h0000;
    operand_b = 16'h0000;
    fail_count = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_cases();
    test_random_pairs();
    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end
endmodule

// ----- half_float_adder.f -----
+incdir+hdl
hdl/hfa_pkg.sv
hdl/hfa_front.sv
hdl/hfa_queue.sv
hdl/hfa_back.sv
hdl/half_float_adder.sv
dv/tb_half_float_adder.sv
